/* src/cftp_pkg.sv */
// Shared types and constants of the circumcircle unit.
package cftp_pkg;

    // Status carried alongside each transaction through the pipeline
    typedef struct packed {
        logic degen;   // determinant magnitude at or below the collinearity limit
        logic ovf;     // center or radius out of the output range
    } cftp_flags_t;

    localparam int LIMIT_W    = 32;
    localparam int APB_DATA_W = 32;
    localparam int REG_ADDR_W = 3;

    // Register index as decoded from paddr[2]
    localparam logic REG_IDX_LIMIT = 1'b0;

endpackage

/* src/cftp_front.sv */
// Geometry front end: differences, cross terms, determinant and quotient operands.
module cftp_front import cftp_pkg::*; #(
    parameter int W = 32,
    localparam int NP_W  = 3 * W + 6,
    localparam int DEN_W = 2 * W + 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic signed [W-1:0] x1,
    input  logic signed [W-1:0] y1,
    input  logic signed [W-1:0] x2,
    input  logic signed [W-1:0] y2,
    input  logic signed [W-1:0] x3,
    input  logic signed [W-1:0] y3,
    input  logic [LIMIT_W-1:0]  limit,
    output logic                out_valid,
    output logic [NP_W-1:0]     out_num_x,
    output logic [NP_W-1:0]     out_num_y,
    output logic [DEN_W-1:0]    out_den,
    output logic                out_neg_x,
    output logic                out_neg_y,
    output logic signed [W-1:0] out_x1,
    output logic signed [W-1:0] out_y1,
    output cftp_flags_t         out_flags
);

    localparam int DW     = W + 1;
    localparam int P_W    = 2 * W + 2;
    localparam int EF_W   = 2 * W + 3;
    localparam int G_W    = 2 * W + 4;
    localparam int LO_W   = W + 1;
    localparam int HI_W   = EF_W - LO_W;
    localparam int PP_W   = 2 * W + 3;
    localparam int PROD_W = 3 * W + 4;
    localparam int NUM_W  = 3 * W + 5;
    localparam int NSTG   = 9;

    logic [NSTG-1:0] v_reg;

    // stage 1
    logic signed [DW-1:0] a1_reg, b1_reg, c1_reg, d1_reg;
    logic signed [DW-1:0] sx12_reg, sy12_reg, sx13_reg, sy13_reg, dy32_reg, dx32_reg;
    logic signed [W-1:0]  x1_1_reg, y1_1_reg;
    // stage 2
    logic signed [P_W-1:0] pa2_reg, pb2_reg, pc2_reg, pd2_reg, pg1_2_reg, pg2_2_reg;
    logic signed [DW-1:0]  a2_reg, b2_reg, c2_reg, d2_reg;
    logic signed [W-1:0]   x1_2_reg, y1_2_reg;
    // stage 3
    logic signed [EF_W-1:0] e3_reg, f3_reg;
    logic signed [G_W-1:0]  g3_reg;
    logic signed [DW-1:0]   a3_reg, b3_reg, c3_reg, d3_reg;
    logic signed [W-1:0]    x1_3_reg, y1_3_reg;
    // stage 4
    logic signed [PP_W-1:0] de_hi4_reg, de_lo4_reg, bf_hi4_reg, bf_lo4_reg;
    logic signed [PP_W-1:0] af_hi4_reg, af_lo4_reg, cme_hi4_reg, cme_lo4_reg;
    logic [G_W-1:0]         gmag4_reg;
    logic                   gneg4_reg, degen4_reg;
    logic signed [W-1:0]    x1_4_reg, y1_4_reg;
    // stage 5
    logic signed [PROD_W-1:0] de5_reg, bf5_reg, af5_reg, cme5_reg;
    logic [G_W-1:0]           gmag5_reg;
    logic                     gneg5_reg, degen5_reg;
    logic signed [W-1:0]      x1_5_reg, y1_5_reg;
    // stage 6
    logic signed [NUM_W-1:0] nx6_reg, ny6_reg;
    logic [G_W-1:0]          gmag6_reg;
    logic                    gneg6_reg, degen6_reg;
    logic signed [W-1:0]     x1_6_reg, y1_6_reg;
    // stage 7
    logic [NUM_W-1:0]    nmx7_reg, nmy7_reg;
    logic                negx7_reg, negy7_reg;
    logic [G_W-1:0]      gmag7_reg;
    logic                degen7_reg;
    logic signed [W-1:0] x1_7_reg, y1_7_reg;
    // stage 8
    logic [NP_W-1:0]     npx8_reg, npy8_reg;
    logic [DEN_W-1:0]    den8_reg;
    logic                negx8_reg, negy8_reg, degen8_reg;
    logic signed [W-1:0] x1_8_reg, y1_8_reg;
    // stage 9
    logic [NP_W-1:0]     npx9_reg, npy9_reg;
    logic [DEN_W-1:0]    den9_reg;
    logic                negx9_reg, negy9_reg;
    cftp_flags_t         flags9_reg;
    logic signed [W-1:0] x1_9_reg, y1_9_reg;

    logic signed [EF_W-1:0] g_diff;
    logic signed [G_W-1:0]  g_next;
    logic signed [HI_W-1:0] e_hi, f_hi;
    logic signed [LO_W:0]   e_lo, f_lo;
    logic [G_W-1:0]         gmag_next;
    logic [NP_W-1:0]        ovf_lim;

    assign g_diff = EF_W'(pg1_2_reg) - EF_W'(pg2_2_reg);
    assign g_next = $signed({g_diff, 1'b0});

    assign e_hi = $signed(e3_reg[EF_W-1:LO_W]);
    assign f_hi = $signed(f3_reg[EF_W-1:LO_W]);
    assign e_lo = $signed({1'b0, e3_reg[LO_W-1:0]});
    assign f_lo = $signed({1'b0, f3_reg[LO_W-1:0]});

    assign gmag_next = g3_reg[G_W-1] ? G_W'(-g3_reg) : G_W'(g3_reg);

    // quotient needs more than W bits once the numerator reaches den * 2^W
    assign ovf_lim = NP_W'({den8_reg, {W{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1: differences and sums
            a1_reg   <= DW'(x2) - DW'(x1);
            b1_reg   <= DW'(y2) - DW'(y1);
            c1_reg   <= DW'(x3) - DW'(x1);
            d1_reg   <= DW'(y3) - DW'(y1);
            sx12_reg <= DW'(x1) + DW'(x2);
            sy12_reg <= DW'(y1) + DW'(y2);
            sx13_reg <= DW'(x1) + DW'(x3);
            sy13_reg <= DW'(y1) + DW'(y3);
            dy32_reg <= DW'(y3) - DW'(y2);
            dx32_reg <= DW'(x3) - DW'(x2);
            x1_1_reg <= x1;
            y1_1_reg <= y1;

            // stage 2: cross products
            pa2_reg   <= a1_reg * sx12_reg;
            pb2_reg   <= b1_reg * sy12_reg;
            pc2_reg   <= c1_reg * sx13_reg;
            pd2_reg   <= d1_reg * sy13_reg;
            pg1_2_reg <= a1_reg * dy32_reg;
            pg2_2_reg <= b1_reg * dx32_reg;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            c2_reg    <= c1_reg;
            d2_reg    <= d1_reg;
            x1_2_reg  <= x1_1_reg;
            y1_2_reg  <= y1_1_reg;

            // stage 3: E, F and doubled determinant
            e3_reg   <= EF_W'(pa2_reg) + EF_W'(pb2_reg);
            f3_reg   <= EF_W'(pc2_reg) + EF_W'(pd2_reg);
            g3_reg   <= g_next;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            c3_reg   <= c2_reg;
            d3_reg   <= d2_reg;
            x1_3_reg <= x1_2_reg;
            y1_3_reg <= y1_2_reg;

            // stage 4: split products of the numerators, determinant check
            de_hi4_reg  <= d3_reg * e_hi;
            de_lo4_reg  <= d3_reg * e_lo;
            bf_hi4_reg  <= b3_reg * f_hi;
            bf_lo4_reg  <= b3_reg * f_lo;
            af_hi4_reg  <= a3_reg * f_hi;
            af_lo4_reg  <= a3_reg * f_lo;
            cme_hi4_reg <= c3_reg * e_hi;
            cme_lo4_reg <= c3_reg * e_lo;
            gmag4_reg   <= gmag_next;
            gneg4_reg   <= g3_reg[G_W-1];
            degen4_reg  <= (gmag_next <= G_W'(limit));
            x1_4_reg    <= x1_3_reg;
            y1_4_reg    <= y1_3_reg;

            // stage 5: recombine the halves
            de5_reg    <= $signed({de_hi4_reg, {LO_W{1'b0}}}) + PROD_W'(de_lo4_reg);
            bf5_reg    <= $signed({bf_hi4_reg, {LO_W{1'b0}}}) + PROD_W'(bf_lo4_reg);
            af5_reg    <= $signed({af_hi4_reg, {LO_W{1'b0}}}) + PROD_W'(af_lo4_reg);
            cme5_reg   <= $signed({cme_hi4_reg, {LO_W{1'b0}}}) + PROD_W'(cme_lo4_reg);
            gmag5_reg  <= gmag4_reg;
            gneg5_reg  <= gneg4_reg;
            degen5_reg <= degen4_reg;
            x1_5_reg   <= x1_4_reg;
            y1_5_reg   <= y1_4_reg;

            // stage 6: numerators
            nx6_reg    <= NUM_W'(de5_reg) - NUM_W'(bf5_reg);
            ny6_reg    <= NUM_W'(af5_reg) - NUM_W'(cme5_reg);
            gmag6_reg  <= gmag5_reg;
            gneg6_reg  <= gneg5_reg;
            degen6_reg <= degen5_reg;
            x1_6_reg   <= x1_5_reg;
            y1_6_reg   <= y1_5_reg;

            // stage 7: magnitudes and quotient signs
            nmx7_reg   <= nx6_reg[NUM_W-1] ? NUM_W'(-nx6_reg) : NUM_W'(nx6_reg);
            nmy7_reg   <= ny6_reg[NUM_W-1] ? NUM_W'(-ny6_reg) : NUM_W'(ny6_reg);
            negx7_reg  <= nx6_reg[NUM_W-1] ^ gneg6_reg;
            negy7_reg  <= ny6_reg[NUM_W-1] ^ gneg6_reg;
            gmag7_reg  <= gmag6_reg;
            degen7_reg <= degen6_reg;
            x1_7_reg   <= x1_6_reg;
            y1_7_reg   <= y1_6_reg;

            // stage 8: round to nearest as floor((2|n| + |g|) / 2|g|)
            npx8_reg   <= NP_W'({nmx7_reg, 1'b0}) + NP_W'(gmag7_reg);
            npy8_reg   <= NP_W'({nmy7_reg, 1'b0}) + NP_W'(gmag7_reg);
            den8_reg   <= {gmag7_reg, 1'b0};
            negx8_reg  <= negx7_reg;
            negy8_reg  <= negy7_reg;
            degen8_reg <= degen7_reg;
            x1_8_reg   <= x1_7_reg;
            y1_8_reg   <= y1_7_reg;

            // stage 9: range pre-check of the quotients
            npx9_reg         <= npx8_reg;
            npy9_reg         <= npy8_reg;
            den9_reg         <= den8_reg;
            negx9_reg        <= negx8_reg;
            negy9_reg        <= negy8_reg;
            flags9_reg.degen <= degen8_reg;
            flags9_reg.ovf   <= (npx8_reg >= ovf_lim) || (npy8_reg >= ovf_lim);
            x1_9_reg         <= x1_8_reg;
            y1_9_reg         <= y1_8_reg;
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_num_x = npx9_reg;
    assign out_num_y = npy9_reg;
    assign out_den   = den9_reg;
    assign out_neg_x = negx9_reg;
    assign out_neg_y = negy9_reg;
    assign out_x1    = x1_9_reg;
    assign out_y1    = y1_9_reg;
    assign out_flags = flags9_reg;

endmodule

/* src/cftp_div.sv */
// Pipelined restoring divider, two numerator lanes over one shared divisor.
module cftp_div #(
    parameter int NP_W  = 102,
    parameter int DEN_W = 69,
    parameter int QB    = 32,
    parameter int SB_W  = 68
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [NP_W-1:0]  in_num_x,
    input  logic [NP_W-1:0]  in_num_y,
    input  logic [DEN_W-1:0] in_den,
    input  logic [SB_W-1:0]  in_sb,
    output logic             out_valid,
    output logic [QB-1:0]    out_q_x,
    output logic [QB-1:0]    out_q_y,
    output logic [SB_W-1:0]  out_sb
);

    logic [QB-1:0]    vld_reg;
    logic [NP_W-1:0]  remx_reg  [QB];
    logic [NP_W-1:0]  remy_reg  [QB];
    logic [DEN_W-1:0] den_reg   [QB];
    logic [QB-1:0]    qx_reg    [QB];
    logic [QB-1:0]    qy_reg    [QB];
    logic [SB_W-1:0]  sb_reg    [QB];
    logic [NP_W-1:0]  remx_next [QB];
    logic [NP_W-1:0]  remy_next [QB];
    logic [QB-1:0]    qx_next   [QB];
    logic [QB-1:0]    qy_next   [QB];

    // one quotient bit per stage, most significant first
    always_comb begin
        logic [NP_W-1:0]  rx, ry;
        logic [DEN_W-1:0] dn;
        logic [QB-1:0]    qx, qy;
        logic [NP_W:0]    sub, dfx, dfy;
        for (int i = 0; i < QB; i++) begin
            if (i == 0) begin
                rx = in_num_x;
                ry = in_num_y;
                dn = in_den;
                qx = '0;
                qy = '0;
            end else begin
                rx = remx_reg[i-1];
                ry = remy_reg[i-1];
                dn = den_reg[i-1];
                qx = qx_reg[i-1];
                qy = qy_reg[i-1];
            end
            sub = (NP_W + 1)'(dn) << (QB - 1 - i);
            dfx = {1'b0, rx} - sub;
            dfy = {1'b0, ry} - sub;
            remx_next[i] = dfx[NP_W] ? rx : dfx[NP_W-1:0];
            remy_next[i] = dfy[NP_W] ? ry : dfy[NP_W-1:0];
            qx_next[i]   = {qx[QB-2:0], ~dfx[NP_W]};
            qy_next[i]   = {qy[QB-2:0], ~dfy[NP_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[QB-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < QB; i++) begin
                remx_reg[i] <= remx_next[i];
                remy_reg[i] <= remy_next[i];
                qx_reg[i]   <= qx_next[i];
                qy_reg[i]   <= qy_next[i];
                den_reg[i]  <= (i == 0) ? in_den : den_reg[(i == 0) ? 0 : i - 1];
                sb_reg[i]   <= (i == 0) ? in_sb : sb_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_q_x   = qx_reg[QB-1];
    assign out_q_y   = qy_reg[QB-1];
    assign out_sb    = sb_reg[QB-1];

endmodule

/* src/cftp_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with final remainder.
module cftp_sqrt #(
    parameter int RB   = 33,
    parameter int SB_W = 66
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [2*RB-1:0] in_s,
    input  logic [SB_W-1:0] in_sb,
    output logic            out_valid,
    output logic [RB-1:0]   out_root,
    output logic [RB+1:0]   out_rem,
    output logic [SB_W-1:0] out_sb
);

    logic [RB-1:0]   vld_reg;
    logic [RB+1:0]   rem_reg   [RB];
    logic [RB-1:0]   root_reg  [RB];
    logic [2*RB-1:0] s_reg     [RB];
    logic [SB_W-1:0] sb_reg    [RB];
    logic [RB+1:0]   rem_next  [RB];
    logic [RB-1:0]   root_next [RB];
    logic [2*RB-1:0] s_next    [RB];

    always_comb begin
        logic [RB+1:0]   rm;
        logic [RB-1:0]   rt;
        logic [2*RB-1:0] sv;
        logic [RB+3:0]   rsh, trial;
        logic            take;
        for (int i = 0; i < RB; i++) begin
            if (i == 0) begin
                rm = '0;
                rt = '0;
                sv = in_s;
            end else begin
                rm = rem_reg[i-1];
                rt = root_reg[i-1];
                sv = s_reg[i-1];
            end
            // bring down the next pair of radicand bits and try root bit one
            rsh          = {rm, sv[2*RB-1 -: 2]};
            trial        = (RB + 4)'({rt, 2'b01});
            take         = (rsh >= trial);
            rem_next[i]  = take ? (RB + 2)'(rsh - trial) : (RB + 2)'(rsh);
            root_next[i] = {rt[RB-2:0], take};
            s_next[i]    = {sv[2*RB-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[RB-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < RB; i++) begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                s_reg[i]    <= s_next[i];
                sb_reg[i]   <= (i == 0) ? in_sb : sb_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign out_valid = vld_reg[RB-1];
    assign out_root  = root_reg[RB-1];
    assign out_rem   = rem_reg[RB-1];
    assign out_sb    = sb_reg[RB-1];

endmodule

/* src/circle_from_three_points.sv */
// Circumcircle unit: center and radius of the circle through three points.
// Throughput one transaction per cycle while the skid spare is empty; a full spare stalls
// the whole pipeline, and otherwise the divider and root pipelines retire one each cycle.
// A two-entry output skid keeps input accepted while one result waits to be taken.
// Synchronous active-low reset empties the pipeline and clears collinear_limit to 0.
module circle_from_three_points import cftp_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    localparam int IN_W  = ((6 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  logic [IN_W-1:0]       s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // center_x, center_y, radius
    output logic [OUT_W-1:0]      m_axis_tdata,
    // valid_res
    output logic [0:0]            m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int W      = COORD_WIDTH;
    localparam int NP_W   = 3 * W + 6;
    localparam int DEN_W  = 2 * W + 5;
    localparam int DSB_W  = 2 * W + 4;
    localparam int RB     = W + 1;
    localparam int SQ_W   = 2 * W + 2;
    localparam int RSB_W  = 2 * W + 2;

    logic adv;

    // configuration
    logic [LIMIT_W-1:0] limit_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_LIMIT) ? APB_DATA_W'(limit_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_LIMIT) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // front end
    logic                fr_valid;
    logic [NP_W-1:0]     fr_num_x, fr_num_y;
    logic [DEN_W-1:0]    fr_den;
    logic                fr_neg_x, fr_neg_y;
    logic signed [W-1:0] fr_x1, fr_y1;
    cftp_flags_t         fr_flags;

    cftp_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .x1        ($signed(s_axis_tdata[0*W +: W])),
        .y1        ($signed(s_axis_tdata[1*W +: W])),
        .x2        ($signed(s_axis_tdata[2*W +: W])),
        .y2        ($signed(s_axis_tdata[3*W +: W])),
        .x3        ($signed(s_axis_tdata[4*W +: W])),
        .y3        ($signed(s_axis_tdata[5*W +: W])),
        .limit     (limit_reg),
        .out_valid (fr_valid),
        .out_num_x (fr_num_x),
        .out_num_y (fr_num_y),
        .out_den   (fr_den),
        .out_neg_x (fr_neg_x),
        .out_neg_y (fr_neg_y),
        .out_x1    (fr_x1),
        .out_y1    (fr_y1),
        .out_flags (fr_flags)
    );

    // divider
    logic                dv_valid;
    logic [W-1:0]        dv_qx, dv_qy;
    logic [DSB_W-1:0]    dv_sb;
    logic                dv_neg_x, dv_neg_y;
    logic [W-1:0]        dv_x1, dv_y1;
    cftp_flags_t         dv_flags;

    cftp_div #(
        .NP_W  (NP_W),
        .DEN_W (DEN_W),
        .QB    (W),
        .SB_W  (DSB_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_num_x  (fr_num_x),
        .in_num_y  (fr_num_y),
        .in_den    (fr_den),
        .in_sb     ({fr_neg_x, fr_neg_y, fr_x1, fr_y1, fr_flags}),
        .out_valid (dv_valid),
        .out_q_x   (dv_qx),
        .out_q_y   (dv_qy),
        .out_sb    (dv_sb)
    );

    assign {dv_neg_x, dv_neg_y, dv_x1, dv_y1, dv_flags} = dv_sb;

    // center, offsets to the first point and their squares
    logic [W-1:0]          cx_abs, cy_abs;
    logic                  fits_x, fits_y;
    logic [2:0]            pv_reg;
    logic [W-1:0]          cx1_reg, cy1_reg, cx2_reg, cy2_reg, cx3_reg, cy3_reg;
    logic signed [W:0]     dx1_reg, dy1_reg;
    logic signed [SQ_W-1:0] sqx2_reg, sqy2_reg;
    logic [SQ_W-1:0]       s3_reg;
    cftp_flags_t           flags1_reg, flags2_reg, flags3_reg;

    assign cx_abs = dv_neg_x ? W'(-dv_qx) : dv_qx;
    assign cy_abs = dv_neg_y ? W'(-dv_qy) : dv_qy;
    // a negative center may reach -2^(W-1), a positive one stays below 2^(W-1)
    assign fits_x = !dv_qx[W-1] || (dv_neg_x && dv_qx[W-2:0] == '0);
    assign fits_y = !dv_qy[W-1] || (dv_neg_y && dv_qy[W-2:0] == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else if (adv) begin
            pv_reg <= {pv_reg[1:0], dv_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx1_reg          <= cx_abs;
            cy1_reg          <= cy_abs;
            dx1_reg          <= (W + 1)'($signed(cx_abs)) - (W + 1)'($signed(dv_x1));
            dy1_reg          <= (W + 1)'($signed(cy_abs)) - (W + 1)'($signed(dv_y1));
            flags1_reg.degen <= dv_flags.degen;
            flags1_reg.ovf   <= dv_flags.ovf || !fits_x || !fits_y;

            sqx2_reg   <= dx1_reg * dx1_reg;
            sqy2_reg   <= dy1_reg * dy1_reg;
            cx2_reg    <= cx1_reg;
            cy2_reg    <= cy1_reg;
            flags2_reg <= flags1_reg;

            s3_reg     <= SQ_W'(sqx2_reg) + SQ_W'(sqy2_reg);
            cx3_reg    <= cx2_reg;
            cy3_reg    <= cy2_reg;
            flags3_reg <= flags2_reg;
        end
    end

    // radius
    logic               sq_valid;
    logic [RB-1:0]      sq_root;
    logic [RB+1:0]      sq_rem;
    logic [RSB_W-1:0]   sq_sb;
    logic [W-1:0]       sq_cx, sq_cy;
    cftp_flags_t        sq_flags;
    logic [W+1:0]       r_round;
    logic               r_ovf, res_ok;

    cftp_sqrt #(
        .RB   (RB),
        .SB_W (RSB_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (pv_reg[2]),
        .in_s      (s3_reg),
        .in_sb     ({cx3_reg, cy3_reg, flags3_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_rem   (sq_rem),
        .out_sb    (sq_sb)
    );

    assign {sq_cx, sq_cy, sq_flags} = sq_sb;

    // round up when the remainder exceeds the root
    assign r_round = (W + 2)'(sq_root) + (W + 2)'(sq_rem > (RB + 2)'(sq_root));
    assign r_ovf   = (r_round[W+1:W] != 2'b00);
    assign res_ok  = !sq_flags.degen && !sq_flags.ovf && !r_ovf;

    logic           fin_valid_reg;
    logic [W-1:0]   fin_cx_reg, fin_cy_reg, fin_r_reg;
    logic           fin_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (adv) begin
            fin_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fin_cx_reg <= res_ok ? sq_cx : '0;
            fin_cy_reg <= res_ok ? sq_cy : '0;
            fin_r_reg  <= res_ok ? r_round[W-1:0] : '0;
            fin_ok_reg <= res_ok;
        end
    end

    // output skid: main register drives the port, spare catches one overflow transaction
    logic               main_valid_reg, spare_valid_reg;
    logic [3*W-1:0]     main_data_reg, spare_data_reg;
    logic               main_ok_reg, spare_ok_reg;
    logic               push, pop;

    assign adv  = !spare_valid_reg;
    assign push = adv && fin_valid_reg;
    assign pop  = main_valid_reg && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (pop) begin
            if (spare_valid_reg) begin
                spare_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                spare_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && spare_valid_reg) begin
            main_data_reg <= spare_data_reg;
            main_ok_reg   <= spare_ok_reg;
        end else if (push && (pop || !main_valid_reg)) begin
            main_data_reg <= {fin_r_reg, fin_cy_reg, fin_cx_reg};
            main_ok_reg   <= fin_ok_reg;
        end
        if (push && main_valid_reg && !pop) begin
            spare_data_reg <= {fin_r_reg, fin_cy_reg, fin_cx_reg};
            spare_ok_reg   <= fin_ok_reg;
        end
    end

    assign s_axis_tready   = adv;
    assign m_axis_tvalid   = main_valid_reg;
    assign m_axis_tdata    = OUT_W'(main_data_reg);
    assign m_axis_tuser[0] = main_ok_reg;

    // spare entry is only ever filled behind a held main entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        spare_valid_reg |-> main_valid_reg)
        else $error("skid spare holds a transaction while main is empty");

    // a flagged result carries all-zero fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("invalid result with non-zero fields");

    // draining the spare frees the pipeline on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (spare_valid_reg && m_axis_tready) |=> (m_axis_tvalid && !spare_valid_reg))
        else $error("skid did not drain spare into main");

endmodule

/* bench/circle_from_three_points_test.sv */
// Self-checking bench for the circumcircle unit: directed, limit, random and back-pressure tests.
module circle_from_three_points_test;
    import cftp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 32;
    localparam int DRAIN_CYCLES = 120;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic signed [CW-1:0] y3, x3, y2, x2, y1, x1;
    } triple_t;

    typedef struct packed {
        logic            ok;
        logic [CW-1:0]   r;
        logic [CW-1:0]   cy;
        logic [CW-1:0]   cx;
    } circle_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [191:0]          s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [95:0]           m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [REG_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    circle_from_three_points #(.COORD_WIDTH(CW)) dut (.*);

    logic [31:0] limit_shadow = '0;
    circle_t     circles_due[$];
    int          mismatches = 0;
    bit          jitter_on = 1'b1;
    int          hold_off = 0;

    initial forever #10 aclk = ~aclk;

    initial begin
        #2ms;
        $display("** circle_from_three_points: FAILED **");
        $finish;
    end

    task automatic report(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic wide_t round_div(input wide_t n, input wide_t g);
        wide_t mn, mg, q;
        mn = n < 0 ? -n : n;
        mg = g < 0 ? -g : g;
        q = (2 * mn + mg) / (2 * mg);
        return ((n < 0) != (g < 0)) ? -q : q;
    endfunction

    function automatic wide_t root_nearest(input wide_t s);
        logic [255:0] acc, t;
        acc = '0;
        for (int b = 127; b >= 0; b--) begin
            t = acc | (256'd1 << b);
            if (t * t <= s) acc = t;
        end
        if (s - acc * acc > acc) acc = acc + 1;
        return acc;
    endfunction

    function automatic circle_t circumcircle(input triple_t p, input logic [31:0] lim);
        wide_t x1, y1, x2, y2, x3, y3, a, b, c, d, e, f, g, cx, cy, dx, dy, r;
        circle_t res;
        x1 = p.x1; y1 = p.y1; x2 = p.x2; y2 = p.y2; x3 = p.x3; y3 = p.y3;
        res = '0;
        a = x2 - x1; b = y2 - y1; c = x3 - x1; d = y3 - y1;
        e = a * (x1 + x2) + b * (y1 + y2);
        f = c * (x1 + x3) + d * (y1 + y3);
        g = 2 * (a * (y3 - y2) - b * (x3 - x2));
        if ((g < 0 ? -g : g) <= wide_t'({224'd0, lim})) return res;
        cx = round_div(d * e - b * f, g);
        cy = round_div(a * f - c * e, g);
        if (cx < -(wide_t'(1) <<< 31) || cx >= (wide_t'(1) <<< 31)) return res;
        if (cy < -(wide_t'(1) <<< 31) || cy >= (wide_t'(1) <<< 31)) return res;
        dx = cx - x1; dy = cy - y1;
        r = root_nearest(dx * dx + dy * dy);
        if (r >= (wide_t'(1) <<< 32)) return res;
        res.cx = cx[31:0]; res.cy = cy[31:0]; res.r = r[31:0]; res.ok = 1'b1;
        return res;
    endfunction

    // result side: check each transaction, then choose tready for the next edge
    always @(posedge aclk) begin
        circle_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser[0], m_axis_tdata[95:64], m_axis_tdata[63:32], m_axis_tdata[31:0]};
            if (circles_due.size() == 0) begin
                report("result with nothing outstanding");
            end else begin
                want = circles_due.pop_front();
                if (got.ok !== want.ok) report($sformatf("valid %b want %b", got.ok, want.ok));
                if (got.cx !== want.cx) report($sformatf("cx %h want %h", got.cx, want.cx));
                if (got.cy !== want.cy) report($sformatf("cy %h want %h", got.cy, want.cy));
                if (got.r !== want.r) report($sformatf("r %h want %h", got.r, want.r));
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !jitter_on || ($urandom_range(0, 99) >= 25);
        end
    end

    task automatic send_triple(input triple_t p);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        circles_due.push_back(circumcircle(p, limit_shadow));
        if (jitter_on && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (circles_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        wait_drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {REG_IDX_LIMIT, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        limit_shadow = v;
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== v) report($sformatf("limit read %h want %h", prdata, v));
        psel <= 1'b0; penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic triple_t make_triple(input int x1, y1, x2, y2, x3, y3);
        triple_t p;
        p.x1 = x1; p.y1 = y1; p.x2 = x2; p.y2 = y2; p.x3 = x3; p.y3 = y3;
        return p;
    endfunction

    function automatic triple_t random_triple();
        triple_t p;
        int kind, span, k;
        kind = $urandom_range(0, 9);
        span = $urandom_range(4, 24);
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind < 5) begin
            // keep points close, so most triples give a circle in range
            p.x1 = $signed($urandom) >>> (32 - span);
            p.y1 = $signed($urandom) >>> (32 - span);
            p.x2 = p.x1 + ($signed($urandom) >>> (32 - span));
            p.y2 = p.y1 + ($signed($urandom) >>> (32 - span));
            p.x3 = p.x1 + ($signed($urandom) >>> (32 - span));
            p.y3 = p.y1 + ($signed($urandom) >>> (32 - span));
        end else if (kind < 7) begin
            // nearly collinear: third point on the line, nudged slightly
            k = $signed($urandom_range(0, 6)) - 3;
            p.x2 = p.x1 + ($signed($urandom) >>> (32 - span));
            p.y2 = p.y1 + ($signed($urandom) >>> (32 - span));
            p.x3 = p.x1 + k * (p.x2 - p.x1) + $signed($urandom_range(0, 4)) - 2;
            p.y3 = p.y1 + k * (p.y2 - p.y1) + $signed($urandom_range(0, 4)) - 2;
        end
        return p;
    endfunction

    task automatic test_directed();
        int mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_triple(make_triple(0, 0, 0, 0, 0, 0));
        send_triple(make_triple(65536, 0, 0, 65536, -65536, 0));
        send_triple(make_triple(0, 0, 131072, 0, 0, 131072));
        send_triple(make_triple(5, 5, 5, 5, 9, 1));
        send_triple(make_triple(0, 0, 1, 1, 2, 2));
        send_triple(make_triple(0, 0, 1, 0, 0, 1));
        send_triple(make_triple(mx, mx, mn, mn, mx, mn));
        send_triple(make_triple(mn, mn, mn, mx, mx, mx));
        send_triple(make_triple(mn, 0, mx, 0, 0, mx));
        send_triple(make_triple(0, 0, mx, 1, mn, 0));
        send_triple(make_triple(0, 0, 1000000, 1, 2000000, 0));
        send_triple(make_triple(mx, mx, mx - 1, mx, mx, mx - 1));
        send_triple(make_triple(-1, -1, -1, 1, 1, -1));
        send_triple(make_triple(mn, mn, mn + 3, mn, mn, mn + 1));
        send_triple(make_triple(0, 0, 3, 0, 0, 2));
        send_triple(make_triple(mx, 0, 0, mx, mn, mn));
    endtask

    task automatic test_limits();
        logic [31:0] lims[5];
        lims = '{32'd1, 32'd40, 32'hFFFF_FFFF, 32'h0001_0000, 32'd0};
        foreach (lims[i]) begin
            write_limit(lims[i]);
            send_triple(make_triple(0, 0, 1, 0, 0, 1));
            send_triple(make_triple(0, 0, 3, 0, 0, 7));
            send_triple(make_triple(0, 0, 65536, 0, 0, 65536));
            repeat (40) send_triple(random_triple());
        end
    endtask

    task automatic test_random();
        for (int i = 0; i < 380; i++) begin
            if (i == 150) jitter_on = 1'b0;
            if (i == 250) jitter_on = 1'b1;
            if (i == 300) write_limit($urandom);
            if (i == 340) write_limit($urandom_range(0, 255));
            send_triple(random_triple());
        end
    endtask

    task automatic test_back_pressure();
        wait_drain();
        hold_off = 400;
        repeat (120) send_triple(random_triple());
        // pause until every outstanding circle has come back
        wait_drain();
        repeat (20) send_triple(random_triple());
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_limits();
        test_random();
        test_back_pressure();
        wait_drain();
        if (mismatches == 0) begin
            $display("** circle_from_three_points: PASSED **");
        end else begin
            $display("** circle_from_three_points: FAILED **");
        end
        $finish;
    end

endmodule
